// ===== rtl/serial_keyword_command_detector_unit_assert.svh =====
// Assertion macros shared by the detector RTL.
`ifndef SERIAL_KEYWORD_COMMAND_DETECTOR_UNIT_ASSERT_SVH
`define SERIAL_KEYWORD_COMMAND_DETECTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define SKCD_ASSERT_IMP(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("assertion failed: consequent did not hold in the same cycle");

// Next-cycle implication, checked out of reset.
`define SKCD_ASSERT_NXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("assertion failed: consequent did not hold in the next cycle");

`else

`define SKCD_ASSERT_IMP(label, clock, resetn, ante, cons)
`define SKCD_ASSERT_NXT(label, clock, resetn, ante, cons)

`endif

`endif

// ===== rtl/skcd_pkg.sv =====
// Types and constants of the serial keyword command detector.
package skcd_pkg;

    localparam int BUFFER_BYTES  = 64;
    localparam int MESSAGE_COUNT = 4;
    localparam int WIN_DEPTH     = 11;
    localparam int LED_COUNT     = 3;
    localparam int FILL_W        = $clog2(BUFFER_BYTES);
    localparam int MSG_W         = (MESSAGE_COUNT > 1) ? $clog2(MESSAGE_COUNT) : 1;
    localparam int TIMER_W       = 16;
    localparam int CFG_IDX_W     = 1;

    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BUFFER_BYTES - 1);

    // Keywords, first character in the most significant byte.
    localparam int LEFT_LEN  = 10;
    localparam int RIGHT_LEN = 11;
    localparam int STOP_LEN  = 4;
    localparam logic [LEFT_LEN*8-1:0]  KEY_LEFT  = "BRAKE LEFT";
    localparam logic [RIGHT_LEN*8-1:0] KEY_RIGHT = "BRAKE RIGHT";
    localparam logic [STOP_LEN*8-1:0]  KEY_STOP  = "STOP";

    localparam logic [TIMER_W-1:0] RESET_ON_MS    = 16'd500;
    localparam logic [TIMER_W-1:0] RESET_INTERVAL = 16'd500;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LED_ON_MS      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TX_INTERVAL_MS = 1'd1;

    typedef enum logic [1:0] {
        ACK_NONE  = 2'd0,
        ACK_LEFT  = 2'd1,
        ACK_RIGHT = 2'd2,
        ACK_STOP  = 2'd3
    } ack_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } cmd_word_t;

    typedef struct packed {
        logic       led_blue;
        logic       led_green;
        logic       led_red;
        logic [1:0] ack_code;
        logic       byte_dropped;
        logic       periodic_valid;
        logic [1:0] periodic_index;
    } rsp_word_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctl_t;

    typedef struct packed {
        logic load;
        logic tick;
    } led_ctl_t;

endpackage

// ===== rtl/skcd_win_cell.sv =====
// One byte cell of the shifting receive window.
`include "serial_keyword_command_detector_unit_assert.svh"

module skcd_win_cell
    import skcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  win_ctl_t   ctl,
    input  logic [7:0] shift_in,
    output logic [7:0] data
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.clear)
        begin
            data_next = 8'd0;
        end
        else if (ctl.shift)
        begin
            data_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= 8'd0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

    `SKCD_ASSERT_NXT(a_clear_zeroes, clk, rst_n, ctl.clear, data_reg == 8'd0)
    `SKCD_ASSERT_NXT(a_shift_loads, clk, rst_n, ctl.shift && !ctl.clear,
                     data_reg == $past(shift_in))
    `SKCD_ASSERT_NXT(a_idle_holds, clk, rst_n, !ctl.shift && !ctl.clear, $stable(data_reg))

endmodule

// ===== rtl/skcd_led_cell.sv =====
// One indicator LED with its on-time countdown.
module skcd_led_cell
    import skcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  led_ctl_t           ctl,
    input  logic [TIMER_W-1:0] on_ms,
    output logic               lit_next
);

    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timer_next;
    logic               lit_reg;

    // A zero on-time lights the LED with an idle timer, so it stays lit.
    always_comb
    begin
        timer_next = timer_reg;
        lit_next   = lit_reg;
        if (ctl.load)
        begin
            timer_next = on_ms;
            lit_next   = 1'b1;
        end
        else if (ctl.tick && (timer_reg != '0))
        begin
            timer_next = timer_reg - 1'b1;
            if (timer_reg == TIMER_W'(1))
            begin
                lit_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            lit_reg   <= 1'b0;
        end
        else
        begin
            timer_reg <= timer_next;
            lit_reg   <= lit_next;
        end
    end

endmodule

// ===== rtl/serial_keyword_command_detector_unit.sv =====
// Top level of the serial keyword command detector.
// Takes words, each a received byte or a millisecond tick. Each word yields
// exactly one result word, registered in the cycle after acceptance; a new
// word is taken in the same cycle that the result leaves, so the sustained
// rate is one word per cycle unless stalled. The last eleven bytes sit in
// eleven byte cells shifting on every byte not dropped; all three keywords
// are compared in parallel against the shifted window in that same cycle.
// Configuration writes are always ready and should be made while idle.
`include "serial_keyword_command_detector_unit_assert.svh"

module serial_keyword_command_detector_unit
    import skcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_word_t            cmd_word,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_word_t            rsp_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIMER_W-1:0]   cfg_data
);

    logic [TIMER_W-1:0] led_on_ms_reg;
    logic [TIMER_W-1:0] tx_interval_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               nul_reg;
    logic               nul_next;
    logic [TIMER_W-1:0] tick_reg;
    logic [TIMER_W-1:0] tick_next;
    logic [MSG_W-1:0]   msg_reg;
    logic [MSG_W-1:0]   msg_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_word_t          rsp_word_reg;
    rsp_word_t          rsp_word_next;

    logic                   accept;
    logic                   is_byte;
    logic                   is_tick;
    logic                   full;
    logic                   byte_ok;
    logic [FILL_W-1:0]      fill_inc;
    logic [TIMER_W-1:0]     tick_inc;
    logic                   fire;
    logic                   nul_seen;
    ack_t                   ack;
    logic [7:0]             win_data  [WIN_DEPTH];
    logic [7:0]             shift_src [WIN_DEPTH];
    logic [WIN_DEPTH*8-1:0] view_flat;
    win_ctl_t               win_ctl;
    led_ctl_t               led_ctl   [LED_COUNT];
    logic [LED_COUNT-1:0]   lit_next;

    assign cmd_stall = rsp_valid_reg & rsp_stall;
    assign accept    = cmd_valid & ~cmd_stall;
    assign is_byte   = accept && (cmd_word.kind == KIND_BYTE);
    assign is_tick   = accept && (cmd_word.kind == KIND_TICK);
    assign full      = (fill_reg == FILL_LAST);
    assign byte_ok   = is_byte && !full;
    assign fill_inc  = fill_reg + 1'b1;
    assign nul_seen  = nul_reg || (cmd_word.rx_byte == 8'd0);
    assign cfg_ready = 1'b1;

    // Window as it stands after this byte; the oldest byte is most significant.
    genvar gi;
    generate
        for (gi = 0; gi < WIN_DEPTH; gi++)
        begin : g_win
            if (gi == WIN_DEPTH - 1)
            begin : g_head
                assign shift_src[gi] = cmd_word.rx_byte;
            end
            else
            begin : g_body
                assign shift_src[gi] = win_data[gi+1];
            end
            assign view_flat[(WIN_DEPTH-1-gi)*8 +: 8] = shift_src[gi];

            skcd_win_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (win_ctl),
                .shift_in (shift_src[gi]),
                .data     (win_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ack = ACK_NONE;
        if (byte_ok && !nul_seen)
        begin
            if ((fill_inc >= FILL_W'(LEFT_LEN)) && (view_flat[LEFT_LEN*8-1:0] == KEY_LEFT))
            begin
                ack = ACK_LEFT;
            end
            else if ((fill_inc >= FILL_W'(RIGHT_LEN))
                     && (view_flat[RIGHT_LEN*8-1:0] == KEY_RIGHT))
            begin
                ack = ACK_RIGHT;
            end
            else if ((fill_inc >= FILL_W'(STOP_LEN))
                     && (view_flat[STOP_LEN*8-1:0] == KEY_STOP))
            begin
                ack = ACK_STOP;
            end
        end
    end

    assign win_ctl.shift = byte_ok;
    assign win_ctl.clear = (is_byte && full) || (ack != ACK_NONE);

    always_comb
    begin
        fill_next = fill_reg;
        nul_next  = nul_reg;
        if (win_ctl.clear)
        begin
            fill_next = '0;
            nul_next  = 1'b0;
        end
        else if (byte_ok)
        begin
            fill_next = fill_inc;
            nul_next  = nul_seen;
        end
    end

    // LED cells: blue follows the left brake, green the right, red the stop.
    assign led_ctl[0] = '{load: (ack == ACK_LEFT),  tick: is_tick};
    assign led_ctl[1] = '{load: (ack == ACK_RIGHT), tick: is_tick};
    assign led_ctl[2] = '{load: (ack == ACK_STOP),  tick: is_tick};

    generate
        for (gi = 0; gi < LED_COUNT; gi++)
        begin : g_led
            skcd_led_cell u_led (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (led_ctl[gi]),
                .on_ms    (led_on_ms_reg),
                .lit_next (lit_next[gi])
            );
        end
    endgenerate

    // Periodic scheduler.
    assign tick_inc = tick_reg + 1'b1;
    assign fire     = is_tick && (tick_inc >= tx_interval_reg);

    always_comb
    begin
        tick_next = tick_reg;
        msg_next  = msg_reg;
        if (is_tick)
        begin
            tick_next = fire ? '0 : tick_inc;
        end
        if (fire)
        begin
            if (msg_reg == MSG_W'(MESSAGE_COUNT - 1))
            begin
                msg_next = '0;
            end
            else
            begin
                msg_next = msg_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        rsp_word_next                = rsp_word_reg;
        rsp_valid_next               = rsp_valid_reg & rsp_stall;
        if (accept)
        begin
            rsp_valid_next               = 1'b1;
            rsp_word_next.led_blue       = lit_next[0];
            rsp_word_next.led_green      = lit_next[1];
            rsp_word_next.led_red        = lit_next[2];
            rsp_word_next.ack_code       = ack;
            rsp_word_next.byte_dropped   = is_byte && full;
            rsp_word_next.periodic_valid = fire;
            rsp_word_next.periodic_index = fire ? 2'(msg_reg) : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_on_ms_reg   <= RESET_ON_MS;
            tx_interval_reg <= RESET_INTERVAL;
            fill_reg        <= '0;
            nul_reg         <= 1'b0;
            tick_reg        <= '0;
            msg_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LED_ON_MS:      led_on_ms_reg   <= cfg_data;
                    REG_TX_INTERVAL_MS: tx_interval_reg <= cfg_data;
                    default:            ;
                endcase
            end
            fill_reg      <= fill_next;
            nul_reg       <= nul_next;
            tick_reg      <= tick_next;
            msg_reg       <= msg_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    `SKCD_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FILL_LAST)
    `SKCD_ASSERT_NXT(a_tick_word, clk, rst_n, is_tick,
                     rsp_valid && (rsp_word.ack_code == ACK_NONE) && !rsp_word.byte_dropped)
    `SKCD_ASSERT_NXT(a_byte_word, clk, rst_n, is_byte, rsp_valid && !rsp_word.periodic_valid)
    `SKCD_ASSERT_NXT(a_match_clears, clk, rst_n, ack != ACK_NONE, fill_reg == '0 && !nul_reg)
    `SKCD_ASSERT_IMP(a_nul_blocks, clk, rst_n, nul_reg, ack == ACK_NONE)

endmodule
